>>> sv/skvt_pkg.sv
`timescale 1ns / 1ps

package skvt_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_UPDATE = 3'd1,
    REQ_LOOKUP = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
    logic upd;
  } cell_ctrl_t;

endpackage

>>> sv/sorted_key_value_table.sv
// The accepting edge registers the key compare in every cell; the edge that ends the
// execute state shifts the cells and registers the result.
// No item is accepted in the execute state or while a result waits under a stall; the
// next item is accepted in the same cycle in which the waiting result is taken.
// Reset: asynchronous and active low; it empties the table and drops any pending result.
`timescale 1ns / 1ps

module sorted_key_value_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [skvt_pkg::REQ_W-1:0]           req_type_i,
  input  logic [skvt_pkg::KEY_W-1:0]           key_i,
  input  logic signed [skvt_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [skvt_pkg::POS_W-1:0]           position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [skvt_pkg::STATUS_W-1:0]        status_o,
  output logic [skvt_pkg::KEY_W-1:0]           key_out_o,
  output logic signed [skvt_pkg::WEIGHT_W-1:0] weight_out_o,
  output logic [skvt_pkg::CNT_W-1:0]           entry_count_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                               state_q;
  logic [CW-1:0]                        count_q, count_d;
  logic                                 out_valid_q;
  logic [skvt_pkg::STATUS_W-1:0]        status_q;
  logic [skvt_pkg::KEY_W-1:0]           key_out_q;
  logic signed [skvt_pkg::WEIGHT_W-1:0] weight_out_q;
  logic [skvt_pkg::CNT_W-1:0]           entry_count_q;

  skvt_pkg::req_e                       req_q;
  logic [skvt_pkg::KEY_W-1:0]           key_q;
  logic signed [skvt_pkg::WEIGHT_W-1:0] weight_q;

  logic                                 in_acc;
  skvt_pkg::cell_ctrl_t                 ctrl;
  skvt_pkg::status_e                    status_d;
  logic [skvt_pkg::KEY_W-1:0]           key_out_d;
  logic signed [skvt_pkg::WEIGHT_W-1:0] weight_out_d;

  logic [TABLE_DEPTH-1:0]               vld, pos_hit, ge, hit, rd;
  logic [skvt_pkg::KEY_W-1:0]           c_key [TABLE_DEPTH];
  logic signed [skvt_pkg::WEIGHT_W-1:0] c_weight [TABLE_DEPTH];
  logic [skvt_pkg::KEY_W-1:0]           c_rd_key [TABLE_DEPTH];
  logic signed [skvt_pkg::WEIGHT_W-1:0] c_rd_weight [TABLE_DEPTH];
  logic [skvt_pkg::KEY_W-1:0]           sel_key;
  logic signed [skvt_pkg::WEIGHT_W-1:0] sel_weight;
  logic                                 found, rd_any;

  assign in_stall_o = (state_q == ST_EXEC) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    assign vld[g]     = (count_q > CW'(g));
    assign pos_hit[g] = ({{(32 - skvt_pkg::POS_W){1'b0}}, position_i} == 32'(g));

    if (g == 0) begin : g_first
      skvt_cell u_cell (
        .clk_i         (clk_i),
        .cmp_en_i      (in_acc),
        .vld_i         (vld[g]),
        .pos_hit_i     (pos_hit[g]),
        .is_read_i     (req_type_i == skvt_pkg::REQ_READ),
        .cmp_key_i     (key_i),
        .ctrl_i        (ctrl),
        .new_key_i     (key_q),
        .new_weight_i  (weight_q),
        .left_ge_i     (1'b0),
        .left_key_i    (key_q),
        .left_weight_i (weight_q),
        .right_key_i   (c_key[(g + 1) % TABLE_DEPTH]),
        .right_weight_i(c_weight[(g + 1) % TABLE_DEPTH]),
        .key_o         (c_key[g]),
        .weight_o      (c_weight[g]),
        .ge_o          (ge[g]),
        .hit_o         (hit[g]),
        .rd_o          (rd[g]),
        .rd_key_o      (c_rd_key[g]),
        .rd_weight_o   (c_rd_weight[g])
      );
    end else if (g == TABLE_DEPTH - 1) begin : g_last
      skvt_cell u_cell (
        .clk_i         (clk_i),
        .cmp_en_i      (in_acc),
        .vld_i         (vld[g]),
        .pos_hit_i     (pos_hit[g]),
        .is_read_i     (req_type_i == skvt_pkg::REQ_READ),
        .cmp_key_i     (key_i),
        .ctrl_i        (ctrl),
        .new_key_i     (key_q),
        .new_weight_i  (weight_q),
        .left_ge_i     (ge[g - 1]),
        .left_key_i    (c_key[g - 1]),
        .left_weight_i (c_weight[g - 1]),
        .right_key_i   (c_key[g]),
        .right_weight_i(c_weight[g]),
        .key_o         (c_key[g]),
        .weight_o      (c_weight[g]),
        .ge_o          (ge[g]),
        .hit_o         (hit[g]),
        .rd_o          (rd[g]),
        .rd_key_o      (c_rd_key[g]),
        .rd_weight_o   (c_rd_weight[g])
      );
    end else begin : g_mid
      skvt_cell u_cell (
        .clk_i         (clk_i),
        .cmp_en_i      (in_acc),
        .vld_i         (vld[g]),
        .pos_hit_i     (pos_hit[g]),
        .is_read_i     (req_type_i == skvt_pkg::REQ_READ),
        .cmp_key_i     (key_i),
        .ctrl_i        (ctrl),
        .new_key_i     (key_q),
        .new_weight_i  (weight_q),
        .left_ge_i     (ge[g - 1]),
        .left_key_i    (c_key[g - 1]),
        .left_weight_i (c_weight[g - 1]),
        .right_key_i   (c_key[g + 1]),
        .right_weight_i(c_weight[g + 1]),
        .key_o         (c_key[g]),
        .weight_o      (c_weight[g]),
        .ge_o          (ge[g]),
        .hit_o         (hit[g]),
        .rd_o          (rd[g]),
        .rd_key_o      (c_rd_key[g]),
        .rd_weight_o   (c_rd_weight[g])
      );
    end
  end

  always_comb begin
    sel_key    = '0;
    sel_weight = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_key    = sel_key | c_rd_key[i];
      sel_weight = sel_weight | c_rd_weight[i];
    end
  end

  assign found  = |hit;
  assign rd_any = |rd;

  always_comb begin
    ctrl         = '0;
    status_d     = skvt_pkg::ST_OK;
    key_out_d    = '0;
    weight_out_d = '0;
    count_d      = count_q;
    if (state_q == ST_EXEC) begin
      unique case (req_q)
        skvt_pkg::REQ_INSERT: begin
          if (found) begin
            status_d = skvt_pkg::ST_DUP;
          end else if (count_q == FULL_CNT) begin
            status_d = skvt_pkg::ST_FULL;
          end else begin
            ctrl.ins     = 1'b1;
            count_d      = count_q + 1'b1;
            key_out_d    = key_q;
            weight_out_d = weight_q;
          end
        end
        skvt_pkg::REQ_UPDATE: begin
          if (found) begin
            ctrl.upd     = 1'b1;
            key_out_d    = key_q;
            weight_out_d = weight_q;
          end else begin
            status_d = skvt_pkg::ST_NOTFOUND;
          end
        end
        skvt_pkg::REQ_LOOKUP: begin
          if (found) begin
            key_out_d    = sel_key;
            weight_out_d = sel_weight;
          end else begin
            status_d = skvt_pkg::ST_NOTFOUND;
          end
        end
        skvt_pkg::REQ_REMOVE: begin
          if (found) begin
            ctrl.rem     = 1'b1;
            count_d      = count_q - 1'b1;
            key_out_d    = sel_key;
            weight_out_d = sel_weight;
          end else begin
            status_d = skvt_pkg::ST_NOTFOUND;
          end
        end
        skvt_pkg::REQ_READ: begin
          if (rd_any) begin
            key_out_d    = sel_key;
            weight_out_d = sel_weight;
          end else begin
            status_d = skvt_pkg::ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= skvt_pkg::req_e'(req_type_i);
      key_q    <= key_i;
      weight_q <= weight_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= '0;
      key_out_q     <= '0;
      weight_out_q  <= '0;
      entry_count_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_acc) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q       <= ST_IDLE;
          count_q       <= count_d;
          out_valid_q   <= 1'b1;
          status_q      <= status_d;
          key_out_q     <= key_out_d;
          weight_out_q  <= weight_out_d;
          entry_count_q <= skvt_pkg::CNT_W'(count_d);
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign key_out_o     = key_out_q;
  assign weight_out_o  = weight_out_q;
  assign entry_count_o = entry_count_q;

`ifndef SYNTH
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> out_valid_q)
    else $error("execution did not produce a result");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count exceeds table depth");

  a_accept_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EXEC)
    else $error("accepted item did not start execution");

  a_count_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_EXEC |=> $stable(count_q))
    else $error("entry count changed outside execution");

  a_no_exec_over_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !out_valid_q)
    else $error("new result would overwrite a waiting result");
`endif

endmodule

>>> sv/skvt_cell.sv
`timescale 1ns / 1ps

module skvt_cell (
  input  logic                              clk_i,
  input  logic                              cmp_en_i,
  input  logic                              vld_i,
  input  logic                              pos_hit_i,
  input  logic                              is_read_i,
  input  logic [skvt_pkg::KEY_W-1:0]        cmp_key_i,
  input  skvt_pkg::cell_ctrl_t              ctrl_i,
  input  logic [skvt_pkg::KEY_W-1:0]        new_key_i,
  input  logic signed [skvt_pkg::WEIGHT_W-1:0] new_weight_i,
  input  logic                              left_ge_i,
  input  logic [skvt_pkg::KEY_W-1:0]        left_key_i,
  input  logic signed [skvt_pkg::WEIGHT_W-1:0] left_weight_i,
  input  logic [skvt_pkg::KEY_W-1:0]        right_key_i,
  input  logic signed [skvt_pkg::WEIGHT_W-1:0] right_weight_i,
  output logic [skvt_pkg::KEY_W-1:0]        key_o,
  output logic signed [skvt_pkg::WEIGHT_W-1:0] weight_o,
  output logic                              ge_o,
  output logic                              hit_o,
  output logic                              rd_o,
  output logic [skvt_pkg::KEY_W-1:0]        rd_key_o,
  output logic signed [skvt_pkg::WEIGHT_W-1:0] rd_weight_o
);

  logic [skvt_pkg::KEY_W-1:0]           key_q;
  logic signed [skvt_pkg::WEIGHT_W-1:0] weight_q;
  logic                                 ge_q;
  logic                                 hit_q;
  logic                                 rd_q;
  logic                                 hit_d;

  assign hit_d = vld_i && (key_q == cmp_key_i);

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      hit_q <= hit_d;
      ge_q  <= !(vld_i && (key_q < cmp_key_i));
      rd_q  <= is_read_i ? (vld_i && pos_hit_i) : hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && ge_q) begin
      if (left_ge_i) begin
        key_q    <= left_key_i;
        weight_q <= left_weight_i;
      end else begin
        key_q    <= new_key_i;
        weight_q <= new_weight_i;
      end
    end else if (ctrl_i.rem && ge_q) begin
      key_q    <= right_key_i;
      weight_q <= right_weight_i;
    end else if (ctrl_i.upd && hit_q) begin
      weight_q <= new_weight_i;
    end
  end

  assign key_o       = key_q;
  assign weight_o    = weight_q;
  assign ge_o        = ge_q;
  assign hit_o       = hit_q;
  assign rd_o        = rd_q;
  assign rd_key_o    = rd_q ? key_q : '0;
  assign rd_weight_o = rd_q ? weight_q : '0;

endmodule

>>> tb/tb_sorted_key_value_table.sv
`timescale 1ns / 1ps

module tb_sorted_key_value_table;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ITEM_TARGET = 950;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 10;

  localparam logic [skvt_pkg::REQ_W-1:0] REQ_SPARE_5 = 3'd5;
  localparam logic [skvt_pkg::REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [skvt_pkg::REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef struct packed {
    skvt_pkg::status_e                     status;
    logic [skvt_pkg::KEY_W-1:0]            key;
    logic signed [skvt_pkg::WEIGHT_W-1:0]  weight;
    logic [skvt_pkg::CNT_W-1:0]            count;
  } table_result_t;

  typedef struct packed {
    logic [skvt_pkg::REQ_W-1:0]            req;
    logic [skvt_pkg::KEY_W-1:0]            key;
    logic signed [skvt_pkg::WEIGHT_W-1:0]  weight;
    logic [skvt_pkg::POS_W-1:0]            pos;
    logic                                  typed;
    table_result_t                         exp;
  } stim_row_t;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic [skvt_pkg::REQ_W-1:0]            req_type_i;
  logic [skvt_pkg::KEY_W-1:0]            key_i;
  logic signed [skvt_pkg::WEIGHT_W-1:0]  weight_i;
  logic [skvt_pkg::POS_W-1:0]            position_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i;
  logic [skvt_pkg::STATUS_W-1:0]         status_o;
  logic [skvt_pkg::KEY_W-1:0]            key_out_o;
  logic signed [skvt_pkg::WEIGHT_W-1:0]  weight_out_o;
  logic [skvt_pkg::CNT_W-1:0]            entry_count_o;

  logic [skvt_pkg::KEY_W-1:0]            tbl_keys [TABLE_DEPTH];
  logic signed [skvt_pkg::WEIGHT_W-1:0]  tbl_weights [TABLE_DEPTH];
  int                                    tbl_count;
  table_result_t                         pending_results [$];

  int  err_cnt;
  int  items_sent;
  int  tx_idle_pct;
  int  rx_stall_pct;
  int  quiet_cycles;
  bit  hold_kick;

  // The expected result is typed in only where it is plain from the table contents.
  stim_row_t directed_rows [22] = '{
    '{skvt_pkg::REQ_READ,   16'h0000, 32'sh00000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_RANGE, 16'h0, 32'sh0, 5'd0}},
    '{skvt_pkg::REQ_LOOKUP, 16'h0000, 32'sh00000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_NOTFOUND, 16'h0, 32'sh0, 5'd0}},
    '{skvt_pkg::REQ_UPDATE, 16'hFFFF, 32'sh7FFFFFFF, 4'd0,  1'b1,
      '{skvt_pkg::ST_NOTFOUND, 16'h0, 32'sh0, 5'd0}},
    '{skvt_pkg::REQ_REMOVE, 16'h1234, 32'sh00000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_NOTFOUND, 16'h0, 32'sh0, 5'd0}},
    '{skvt_pkg::REQ_INSERT, 16'h8000, 32'sh80000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_OK, 16'h8000, 32'sh80000000, 5'd1}},
    '{skvt_pkg::REQ_INSERT, 16'h8000, 32'sh00000001, 4'd0,  1'b1,
      '{skvt_pkg::ST_DUP, 16'h0, 32'sh0, 5'd1}},
    '{skvt_pkg::REQ_INSERT, 16'h0000, 32'sh7FFFFFFF, 4'd0,  1'b1,
      '{skvt_pkg::ST_OK, 16'h0000, 32'sh7FFFFFFF, 5'd2}},
    '{skvt_pkg::REQ_INSERT, 16'hFFFF, 32'shFFFFFFFF, 4'd0,  1'b1,
      '{skvt_pkg::ST_OK, 16'hFFFF, 32'shFFFFFFFF, 5'd3}},
    '{skvt_pkg::REQ_READ,   16'h0000, 32'sh00000000, 4'd2,  1'b1,
      '{skvt_pkg::ST_OK, 16'hFFFF, 32'shFFFFFFFF, 5'd3}},
    '{skvt_pkg::REQ_READ,   16'h0000, 32'sh00000000, 4'd3,  1'b1,
      '{skvt_pkg::ST_RANGE, 16'h0, 32'sh0, 5'd3}},
    '{skvt_pkg::REQ_UPDATE, 16'h8000, 32'sh5A5A5A5A, 4'd0,  1'b1,
      '{skvt_pkg::ST_OK, 16'h8000, 32'sh5A5A5A5A, 5'd3}},
    '{skvt_pkg::REQ_LOOKUP, 16'h8000, 32'sh00000000, 4'd0,  1'b0, '0},
    '{skvt_pkg::REQ_READ,   16'hFFFF, 32'shFFFFFFFF, 4'd15, 1'b1,
      '{skvt_pkg::ST_RANGE, 16'h0, 32'sh0, 5'd3}},
    '{REQ_SPARE_5,          16'hABCD, 32'sh12345678, 4'd7,  1'b1,
      '{skvt_pkg::ST_OK, 16'h0, 32'sh0, 5'd3}},
    '{REQ_SPARE_6,          16'h8000, 32'sh00000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_OK, 16'h0, 32'sh0, 5'd3}},
    '{REQ_SPARE_7,          16'hFFFF, 32'shFFFFFFFF, 4'd15, 1'b1,
      '{skvt_pkg::ST_OK, 16'h0, 32'sh0, 5'd3}},
    '{skvt_pkg::REQ_INSERT, 16'h7FFF, 32'sh00000000, 4'd0,  1'b0, '0},
    '{skvt_pkg::REQ_REMOVE, 16'h0000, 32'sh00000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_OK, 16'h0000, 32'sh7FFFFFFF, 5'd3}},
    '{skvt_pkg::REQ_READ,   16'h0000, 32'sh00000000, 4'd0,  1'b0, '0},
    '{skvt_pkg::REQ_REMOVE, 16'hFFFF, 32'sh00000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_OK, 16'hFFFF, 32'shFFFFFFFF, 5'd2}},
    '{skvt_pkg::REQ_LOOKUP, 16'hFFFF, 32'sh00000000, 4'd0,  1'b1,
      '{skvt_pkg::ST_NOTFOUND, 16'h0, 32'sh0, 5'd2}},
    '{skvt_pkg::REQ_READ,   16'h0000, 32'sh00000000, 4'd15, 1'b1,
      '{skvt_pkg::ST_RANGE, 16'h0, 32'sh0, 5'd2}}
  };

  sorted_key_value_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .weight_i     (weight_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .key_out_o    (key_out_o),
    .weight_out_o (weight_out_o),
    .entry_count_o(entry_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic table_result_t predict_table_request(
    input logic [skvt_pkg::REQ_W-1:0] req, input logic [skvt_pkg::KEY_W-1:0] key,
    input logic signed [skvt_pkg::WEIGHT_W-1:0] weight,
    input logic [skvt_pkg::POS_W-1:0] pos);
    table_result_t res;
    int slot;
    res = '0;
    res.status = skvt_pkg::ST_OK;
    slot = tbl_count;
    for (int i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_keys[i] == key) slot = i;
    end
    case (req)
      skvt_pkg::REQ_INSERT: begin
        if (slot < tbl_count) begin
          res.status = skvt_pkg::ST_DUP;
        end else if (tbl_count >= TABLE_DEPTH) begin
          res.status = skvt_pkg::ST_FULL;
        end else begin
          slot = 0;
          while (slot < tbl_count && tbl_keys[slot] < key) slot++;
          for (int j = tbl_count; j > slot; j--) begin
            tbl_keys[j] = tbl_keys[j-1];
            tbl_weights[j] = tbl_weights[j-1];
          end
          tbl_keys[slot] = key;
          tbl_weights[slot] = weight;
          tbl_count++;
          res.key = key;
          res.weight = weight;
        end
      end
      skvt_pkg::REQ_UPDATE: begin
        if (slot < tbl_count) begin
          tbl_weights[slot] = weight;
          res.key = key;
          res.weight = weight;
        end else begin
          res.status = skvt_pkg::ST_NOTFOUND;
        end
      end
      skvt_pkg::REQ_LOOKUP: begin
        if (slot < tbl_count) begin
          res.key = tbl_keys[slot];
          res.weight = tbl_weights[slot];
        end else begin
          res.status = skvt_pkg::ST_NOTFOUND;
        end
      end
      skvt_pkg::REQ_REMOVE: begin
        if (slot < tbl_count) begin
          res.key = tbl_keys[slot];
          res.weight = tbl_weights[slot];
          for (int j = slot; j + 1 < tbl_count; j++) begin
            tbl_keys[j] = tbl_keys[j+1];
            tbl_weights[j] = tbl_weights[j+1];
          end
          tbl_count--;
        end else begin
          res.status = skvt_pkg::ST_NOTFOUND;
        end
      end
      skvt_pkg::REQ_READ: begin
        if (int'(pos) < tbl_count) begin
          res.key = tbl_keys[pos];
          res.weight = tbl_weights[pos];
        end else begin
          res.status = skvt_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    res.count = skvt_pkg::CNT_W'(tbl_count);
    return res;
  endfunction

  function automatic logic [skvt_pkg::KEY_W-1:0] present_key();
    return tbl_keys[$urandom_range(tbl_count - 1, 0)];
  endfunction

  // Keys already in the table and their neighbors make hits and tight ordering common.
  function automatic logic [skvt_pkg::KEY_W-1:0] pick_key();
    logic [skvt_pkg::KEY_W-1:0] k;
    k = skvt_pkg::KEY_W'($urandom);
    case ($urandom_range(4, 0))
      2: if (tbl_count > 0) k = present_key();
      3: if (tbl_count > 0) k = present_key() + ($urandom_range(1, 0) ? 16'd1 : 16'hFFFF);
      4: k = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      default: begin
      end
    endcase
    return k;
  endfunction

  function automatic logic signed [skvt_pkg::WEIGHT_W-1:0] pick_weight();
    logic signed [skvt_pkg::WEIGHT_W-1:0] w;
    w = skvt_pkg::WEIGHT_W'($urandom);
    case ($urandom_range(15, 0))
      0: w = 32'sh80000000;
      1: w = 32'sh7FFFFFFF;
      2: w = 32'sh00000000;
      3: w = 32'shFFFFFFFF;
      default: begin
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic send_item(input logic [skvt_pkg::REQ_W-1:0] req,
                           input logic [skvt_pkg::KEY_W-1:0] key,
                           input logic signed [skvt_pkg::WEIGHT_W-1:0] weight,
                           input logic [skvt_pkg::POS_W-1:0] pos,
                           input logic typed = 1'b0, input table_result_t typed_res = '0);
    table_result_t predicted;
    @(negedge clk_i);
    while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    key_i      <= key;
    weight_i   <= weight;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_table_request(req, key, weight, pos);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic fill_table();
    while (tbl_count < TABLE_DEPTH) begin
      send_item(skvt_pkg::REQ_INSERT, pick_key(), pick_weight(),
                skvt_pkg::POS_W'($urandom));
    end
    send_item(skvt_pkg::REQ_INSERT, present_key(), pick_weight(),
              skvt_pkg::POS_W'($urandom));
    send_item(skvt_pkg::REQ_INSERT, skvt_pkg::KEY_W'($urandom), pick_weight(),
              skvt_pkg::POS_W'($urandom));
    send_item(skvt_pkg::REQ_READ, pick_key(), pick_weight(), 4'd15);
  endtask

  task automatic mixed_requests(input int n);
    logic [skvt_pkg::REQ_W-1:0] req;
    int sel;
    repeat (n) begin
      sel = $urandom_range(99, 0);
      if (sel < 25) req = skvt_pkg::REQ_INSERT;
      else if (sel < 40) req = skvt_pkg::REQ_UPDATE;
      else if (sel < 60) req = skvt_pkg::REQ_LOOKUP;
      else if (sel < 80) req = skvt_pkg::REQ_REMOVE;
      else if (sel < 95) req = skvt_pkg::REQ_READ;
      else req = skvt_pkg::REQ_W'($urandom_range(REQ_SPARE_7, REQ_SPARE_5));
      send_item(req, pick_key(), pick_weight(), skvt_pkg::POS_W'($urandom));
    end
  endtask

  task automatic drain_table();
    while (tbl_count > 0) begin
      if ($urandom_range(3, 0) == 0) begin
        send_item($urandom_range(1, 0) ? skvt_pkg::REQ_LOOKUP : skvt_pkg::REQ_READ,
                  pick_key(), pick_weight(), skvt_pkg::POS_W'($urandom));
      end else begin
        send_item(skvt_pkg::REQ_REMOVE, present_key(), pick_weight(),
                  skvt_pkg::POS_W'($urandom));
      end
    end
    send_item(skvt_pkg::REQ_REMOVE, pick_key(), pick_weight(), skvt_pkg::POS_W'($urandom));
    send_item(skvt_pkg::REQ_READ, pick_key(), pick_weight(), 4'd0);
  endtask

  initial begin
    int round;
    err_cnt      = 0;
    items_sent   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_kick    = 1'b0;
    tbl_count    = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = '0;
    key_i        = '0;
    weight_i     = '0;
    position_i   = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req, directed_rows[i].key, directed_rows[i].weight,
                directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].exp);
    end

    round = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_for_results();
      case (round % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      fill_table();
      if (round == 0) hold_kick = 1'b1;
      mixed_requests(30);
      drain_table();
      round++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_kick) begin
        hold_kick = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= (rx_stall_pct != 0) && ($urandom_range(99, 0) < rx_stall_pct);
    end
  end

  initial begin
    table_result_t exp;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          exp = pending_results.pop_front();
          if (status_o !== exp.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, exp.status));
          if (key_out_o !== exp.key)
            report_mismatch($sformatf("key got %h want %h", key_out_o, exp.key));
          if (weight_out_o !== exp.weight)
            report_mismatch($sformatf("weight got %h want %h", weight_out_o, exp.weight));
          if (entry_count_o !== exp.count)
            report_mismatch($sformatf("count got %0d want %0d", entry_count_o, exp.count));
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
sv/skvt_pkg.sv
sv/skvt_cell.sv
sv/sorted_key_value_table.sv
tb/tb_sorted_key_value_table.sv
